>>> rtl/wsc_pkg.sv
// Shared types, codes and constants of the wavetable sound chip.
package wsc_pkg;

    localparam int NUM_VOICES = 8;
    localparam int RAM_BYTES  = 128;
    localparam int RAM_AW     = 7;
    localparam int VOICE_W    = 3;

    // Divider: numerator is BASE_RATE * active voices (23 bits)
    localparam logic [19:0] BASE_RATE = 20'hF0000;
    localparam int          DIV_W     = 23;
    localparam logic [4:0]  DIV_LAST  = 5'(DIV_W - 1);

    localparam logic [7:0] LEN_MASK     = 8'h1C;
    localparam logic [5:0] LEN_BASE     = 6'h20;
    localparam logic [5:0] LEN_RESET    = 6'd16;
    localparam logic [3:0] VOICES_RESET = 4'd8;

    // Voice register offsets within an 8-byte voice block
    localparam logic [2:0] REG_FREQ_LO  = 3'd0;
    localparam logic [2:0] REG_FREQ_MID = 3'd2;
    localparam logic [2:0] REG_FREQ_HI  = 3'd4;
    localparam logic [2:0] REG_WAVE     = 3'd6;
    localparam logic [2:0] REG_VOLUME   = 3'd7;

    typedef enum logic [1:0] {
        CMD_ADDR  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] value;
        logic [7:0] cycles;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         read_data;
        logic signed [15:0] sample;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADDR,
        OP_WRITE,
        OP_READ_ISSUE,
        OP_READ_DONE,
        OP_TICK_INIT,
        OP_SKIP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_STEP,
        OP_FETCH_ISSUE,
        OP_FETCH_DONE,
        OP_ACCUM,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        cmd_t cmd;
        logic freq_zero;
        logic div_last;
        logic more;
        logic moved;
        logic last_voice;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/wsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module wsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/wsc_datapath.sv
// Datapath: wave RAM, voice registers, period divider, phase stepper, mixer.
module wsc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  wsc_pkg::dp_op_t     op,
    output wsc_pkg::dp_status_t status,
    input  wsc_pkg::in_item_t   item,
    output logic                result_valid,
    input  logic                result_stall,
    output wsc_pkg::out_item_t  result
);

    localparam int AW = wsc_pkg::RAM_AW;
    localparam int NV = wsc_pkg::NUM_VOICES;

    // latched item
    wsc_pkg::cmd_t cmd_reg;
    logic [7:0]    value_reg;
    logic [7:0]    cycles_reg;

    // global registers
    logic [AW-1:0] ptr_reg;
    logic          autoinc_reg;
    logic [3:0]    active_reg;
    logic          valid_reg [wsc_pkg::RAM_BYTES];

    // per-voice registers
    logic [17:0] freq_reg  [NV];
    logic [5:0]  len_reg   [NV];
    logic [7:0]  wave_reg  [NV];
    logic [3:0]  vol_reg   [NV];
    logic [4:0]  pos_reg   [NV];
    logic [3:0]  nib_reg   [NV];
    logic [23:0] phase_reg [NV];

    // tick working registers
    logic [wsc_pkg::VOICE_W-1:0] vidx_reg;
    logic [wsc_pkg::DIV_W-1:0]   num_reg;
    logic [17:0]                 rem_reg;
    logic [4:0]                  dcnt_reg;
    logic [24:0]                 phase_w_reg;
    logic [4:0]                  pos_w_reg;
    logic [3:0]                  nib_w_reg;
    logic                        moved_reg;
    logic signed [10:0]          sum_reg;
    logic [7:0]                  rd_reg;
    logic                        rvalid_reg;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    // helpers
    logic [AW-1:0]      ptr_bump;
    logic [7:0]         naddr;
    logic [18:0]        trial;
    logic               q_bit;
    logic [17:0]        rem_next;
    logic [5:0]         pos_inc;
    logic [3:0]         nib_sel;
    logic signed [4:0]  nib_s;
    logic signed [4:0]  vol_s;
    logic signed [9:0]  contrib;
    logic [5:0]         new_len;
    logic [wsc_pkg::VOICE_W-1:0] wch;

    assign ptr_bump  = autoinc_reg ? ptr_reg + AW'(1) : ptr_reg;
    assign naddr     = wave_reg[vidx_reg] + {3'b0, pos_w_reg};
    assign ram_we    = (op == wsc_pkg::OP_WRITE);
    assign ram_raddr = (op == wsc_pkg::OP_FETCH_ISSUE) ? naddr[7:1] : ptr_reg;

    // restoring divider step
    assign trial    = {rem_reg, num_reg[wsc_pkg::DIV_W-1]};
    assign q_bit    = (trial >= {1'b0, freq_reg[vidx_reg]});
    assign rem_next = q_bit ? 18'(trial - {1'b0, freq_reg[vidx_reg]}) : trial[17:0];

    // position advance modulo length
    assign pos_inc = {1'b0, pos_w_reg} + 6'd1;

    // voice contribution
    assign nib_sel = moved_reg ? nib_w_reg : nib_reg[vidx_reg];
    assign nib_s   = $signed({1'b0, nib_sel}) - 5'sd8;
    assign vol_s   = $signed({1'b0, vol_reg[vidx_reg]});
    assign contrib = nib_s * vol_s;

    assign wch     = ptr_reg[5:3];
    assign new_len = 6'(wsc_pkg::LEN_BASE - 6'(value_reg & wsc_pkg::LEN_MASK));

    // status to controller
    always_comb
    begin
        status.cmd        = cmd_reg;
        status.freq_zero  = (freq_reg[vidx_reg] == 18'd0);
        status.div_last   = (dcnt_reg == wsc_pkg::DIV_LAST);
        status.more       = (phase_w_reg > {2'b0, num_reg});
        status.moved      = moved_reg;
        status.last_voice = (vidx_reg == wsc_pkg::VOICE_W'(NV - 1));
        status.out_free   = !result_valid || !result_stall;
    end

    wsc_ram #(
        .WIDTH (8),
        .DEPTH (wsc_pkg::RAM_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (value_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= wsc_pkg::CMD_ADDR;
            value_reg    <= '0;
            cycles_reg   <= '0;
            ptr_reg      <= '0;
            autoinc_reg  <= 1'b1;
            active_reg   <= wsc_pkg::VOICES_RESET;
            for (int i = 0; i < wsc_pkg::RAM_BYTES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NV; i++)
            begin
                freq_reg[i]  <= '0;
                len_reg[i]   <= wsc_pkg::LEN_RESET;
                wave_reg[i]  <= '0;
                vol_reg[i]   <= '0;
                pos_reg[i]   <= '0;
                nib_reg[i]   <= '0;
                phase_reg[i] <= '0;
            end
            vidx_reg     <= '0;
            num_reg      <= '0;
            rem_reg      <= '0;
            dcnt_reg     <= '0;
            phase_w_reg  <= '0;
            pos_w_reg    <= '0;
            nib_w_reg    <= '0;
            moved_reg    <= 1'b0;
            sum_reg      <= '0;
            rd_reg       <= '0;
            rvalid_reg   <= 1'b0;
            result_valid <= 1'b0;
            result       <= '0;
        end
        else
        begin
            rvalid_reg <= valid_reg[ram_raddr];

            // output register drains on transfer unless refilled this cycle
            if (result_valid && !result_stall && op != wsc_pkg::OP_EMIT)
            begin
                result_valid <= 1'b0;
            end

            case (op)
                wsc_pkg::OP_LOAD:
                begin
                    cmd_reg    <= item.command;
                    value_reg  <= item.value;
                    cycles_reg <= item.cycles;
                    rd_reg     <= '0;
                    sum_reg    <= '0;
                end
                wsc_pkg::OP_ADDR:
                begin
                    ptr_reg     <= value_reg[AW-1:0];
                    autoinc_reg <= value_reg[7];
                end
                wsc_pkg::OP_WRITE:
                begin
                    valid_reg[ptr_reg] <= 1'b1;
                    ptr_reg            <= ptr_bump;
                    if (ptr_reg[6])
                    begin
                        case (ptr_reg[2:0])
                            wsc_pkg::REG_FREQ_LO:
                                freq_reg[wch][7:0] <= value_reg;
                            wsc_pkg::REG_FREQ_MID:
                                freq_reg[wch][15:8] <= value_reg;
                            wsc_pkg::REG_FREQ_HI:
                            begin
                                freq_reg[wch][17:16] <= value_reg[1:0];
                                if (len_reg[wch] != new_len)
                                begin
                                    len_reg[wch] <= new_len;
                                    pos_reg[wch] <= '0;
                                end
                            end
                            wsc_pkg::REG_WAVE:
                                wave_reg[wch] <= value_reg;
                            wsc_pkg::REG_VOLUME:
                            begin
                                vol_reg[wch] <= value_reg[3:0];
                                if (wch == wsc_pkg::VOICE_W'(NV - 1))
                                begin
                                    active_reg <= 4'd1 + {1'b0, value_reg[6:4]};
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                wsc_pkg::OP_READ_DONE:
                begin
                    rd_reg  <= rvalid_reg ? ram_rdata : 8'd0;
                    ptr_reg <= ptr_bump;
                end
                wsc_pkg::OP_TICK_INIT:
                    vidx_reg <= wsc_pkg::VOICE_W'(4'd8 - active_reg);
                wsc_pkg::OP_SKIP:
                    vidx_reg <= vidx_reg + 1'b1;
                wsc_pkg::OP_DIV_INIT:
                begin
                    num_reg     <= wsc_pkg::DIV_W'(24'(wsc_pkg::BASE_RATE) * 24'(active_reg));
                    rem_reg     <= '0;
                    dcnt_reg    <= '0;
                    phase_w_reg <= 25'(phase_reg[vidx_reg]) + 25'(cycles_reg);
                    pos_w_reg   <= pos_reg[vidx_reg];
                    moved_reg   <= 1'b0;
                end
                wsc_pkg::OP_DIV_STEP:
                begin
                    rem_reg  <= rem_next;
                    num_reg  <= {num_reg[wsc_pkg::DIV_W-2:0], q_bit};
                    dcnt_reg <= dcnt_reg + 5'd1;
                end
                wsc_pkg::OP_STEP:
                begin
                    phase_w_reg <= phase_w_reg - {2'b0, num_reg};
                    pos_w_reg   <= (pos_inc >= len_reg[vidx_reg]) ? 5'd0 : pos_inc[4:0];
                    moved_reg   <= 1'b1;
                end
                wsc_pkg::OP_FETCH_DONE:
                begin
                    if (!rvalid_reg)
                        nib_w_reg <= 4'd0;
                    else if (naddr[0])
                        nib_w_reg <= ram_rdata[7:4];
                    else
                        nib_w_reg <= ram_rdata[3:0];
                end
                wsc_pkg::OP_ACCUM:
                begin
                    phase_reg[vidx_reg] <= phase_w_reg[23:0];
                    pos_reg[vidx_reg]   <= pos_w_reg;
                    nib_reg[vidx_reg]   <= nib_sel;
                    sum_reg             <= sum_reg + 11'(contrib);
                    vidx_reg            <= vidx_reg + 1'b1;
                end
                wsc_pkg::OP_EMIT:
                begin
                    result_valid     <= 1'b1;
                    result.read_data <= rd_reg;
                    result.sample    <= (cmd_reg == wsc_pkg::CMD_TICK) ?
                                        {sum_reg, 5'b0} : 16'sd0;
                end
                default:
                begin
                end
            endcase
        end
    end

endmodule

>>> rtl/wsc_ctrl.sv
// Controller: sequences item decode, RAM access and the per-voice tick loop.
module wsc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  wsc_pkg::dp_status_t status,
    output wsc_pkg::dp_op_t     op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_VOICE,
        S_DIV,
        S_STEP,
        S_FDATA,
        S_ACCUM,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign item_stall = (state_reg != S_IDLE);

    // next state and datapath op
    always_comb
    begin
        state_next = state_reg;
        op         = wsc_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    op         = wsc_pkg::OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (status.cmd)
                    wsc_pkg::CMD_ADDR:
                    begin
                        op         = wsc_pkg::OP_ADDR;
                        state_next = S_EMIT;
                    end
                    wsc_pkg::CMD_WRITE:
                    begin
                        op         = wsc_pkg::OP_WRITE;
                        state_next = S_EMIT;
                    end
                    wsc_pkg::CMD_READ:
                    begin
                        op         = wsc_pkg::OP_READ_ISSUE;
                        state_next = S_RD_WAIT;
                    end
                    default:
                    begin
                        op         = wsc_pkg::OP_TICK_INIT;
                        state_next = S_VOICE;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                op         = wsc_pkg::OP_READ_DONE;
                state_next = S_EMIT;
            end
            S_VOICE:
            begin
                if (status.freq_zero)
                begin
                    op = wsc_pkg::OP_SKIP;
                    if (status.last_voice)
                        state_next = S_EMIT;
                end
                else
                begin
                    op         = wsc_pkg::OP_DIV_INIT;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                op = wsc_pkg::OP_DIV_STEP;
                if (status.div_last)
                    state_next = S_STEP;
            end
            S_STEP:
            begin
                if (status.more)
                    op = wsc_pkg::OP_STEP;
                else if (status.moved)
                begin
                    op         = wsc_pkg::OP_FETCH_ISSUE;
                    state_next = S_FDATA;
                end
                else
                    state_next = S_ACCUM;
            end
            S_FDATA:
            begin
                op         = wsc_pkg::OP_FETCH_DONE;
                state_next = S_ACCUM;
            end
            S_ACCUM:
            begin
                op         = wsc_pkg::OP_ACCUM;
                state_next = status.last_voice ? S_EMIT : S_VOICE;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    op         = wsc_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> rtl/wavetable_sound_chip_8ch_unit.sv
// Top level of the eight-voice 4-bit wavetable sound chip.
// One item is in work at a time; its result lands in an output register, so
// the next item is taken while that result waits. Address-port and data-port
// writes pass through load, decode and emit states; data-port reads add a
// wait state for the one registered RAM read. A tick loads and decodes, then,
// for each active voice, skips a voice whose frequency is zero and otherwise
// advances it k wave steps, fetching a new nibble only when k is not zero: the
// period comes from a shared one-bit-per-cycle divider, the phase loop runs
// one step per cycle, and a wave fetch is a registered read on the RAM read
// port. k can grow very large right after a frequency or voice-count change
// shrinks the period. Wave RAM content after reset reads as zero through
// per-byte valid flags; no clearing pass is run.
module wavetable_sound_chip_8ch_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  wsc_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output wsc_pkg::out_item_t result
);

    wsc_pkg::dp_op_t     op;
    wsc_pkg::dp_status_t status;

    wsc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .op         (op)
    );

    wsc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

>>> rtl/wsc_checker.sv
// Port-level checker for the wavetable sound chip, bound to the top level.
module wsc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input wsc_pkg::in_item_t  item,
    input logic               result_valid,
    input logic               result_stall,
    input wsc_pkg::out_item_t result
);

    // a stalled result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // an accepted item makes the block busy
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("input not stalled after transfer");

    // a stalled input item stays offered and unchanged
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("input item changed while stalled");

    // a result is either a read or a sample, never both
    a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.read_data == 8'd0 || result.sample == 16'sd0))
        else $error("read_data and sample both nonzero");

    // mixer output is a multiple of 32
    a_sample_scale: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.sample[4:0] == 5'd0))
        else $error("sample low bits nonzero");

endmodule

bind wavetable_sound_chip_8ch_unit wsc_checker u_wsc_checker (.*);
